// ----- hdl/stratified_hemisphere_sample_macros.svh -----
// Assertion macros used by the checker file.
`ifndef STRATIFIED_HEMISPHERE_SAMPLE_MACROS_SVH
`define STRATIFIED_HEMISPHERE_SAMPLE_MACROS_SVH

// Same-cycle implication, off during reset.
`define SHS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, live during reset.
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/shs_pkg.sv -----
// Types and constants of the stratified hemisphere sampler.
package shs_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int GRID_MAX      = 16;
  localparam int OUT_SHIFT     = 60 - OUT_FRAC_BITS;
  localparam int OUT_LIM       = ((1 << OUT_FRAC_BITS) > 32767) ? 32767 : (1 << OUT_FRAC_BITS);

  localparam logic [29:0] PI4_Q30 = 30'd843314857;

  localparam int ROOT_W = 31;
  localparam int PHI_W  = 30;
  localparam int TRIG_W = 31;
  localparam int ZQ_W   = 15;

  localparam logic [6:0] K_COS [5] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [6:0] K_SIN [5] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

  localparam logic [31:0] R_COS [5] = '{
    32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12), 32'((64'd1 << 32) / 64'd2)};
  localparam logic [31:0] R_SIN [5] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6)};

  typedef struct packed {
    logic [3:0] cell_x;
    logic [3:0] cell_y;
  } cell_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               is_null;
  } dir_t;

  typedef struct packed {
    logic valid;
    logic na_neg;
    logic nb_neg;
    logic swap;
    logic is_null;
  } ctx_t;

  typedef struct packed {
    ctx_t             ctx;
    logic [PHI_W-1:0] phi;
    logic [ZQ_W-1:0]  zq;
  } root_side_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [ZQ_W-1:0]   zq;
    logic [ROOT_W-1:0] w;
  } trig_side_t;

endpackage

// ----- hdl/shs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module shs_div import shs_pkg::*; #(
  parameter int NUM_W  = 35,
  parameter int DEN_W  = 5,
  parameter int QUO_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic [QUO_W-1:0]  quotient,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_a  [QUO_W+1];
  logic [QUO_W-1:0]  low_a  [QUO_W+1];
  logic [QUO_W-1:0]  quo_a  [QUO_W+1];
  logic [DEN_W-1:0]  den_a  [QUO_W+1];
  logic [SIDE_W-1:0] side_a [QUO_W+1];

  assign rem_a[0]  = DEN_W'(dividend >> QUO_W);
  assign low_a[0]  = dividend[QUO_W-1:0];
  assign quo_a[0]  = '0;
  assign den_a[0]  = divisor;
  assign side_a[0] = side_in;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem_a[i], low_a[i][QUO_W-1]};
      ge    = (trial >= {1'b0, den_a[i]});
    end

    always_ff @(posedge clk) begin
      rem_a[i+1] <= ge ? DEN_W'(trial - {1'b0, den_a[i]}) : trial[DEN_W-1:0];
      low_a[i+1] <= low_a[i] << 1;
      quo_a[i+1] <= {quo_a[i][QUO_W-2:0], ge};
      den_a[i+1] <= den_a[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_a[i+1] <= '0;
      end else begin
        side_a[i+1] <= side_a[i];
      end
    end
  end

  assign quotient = quo_a[QUO_W];
  assign side_out = side_a[QUO_W];

endmodule

// ----- hdl/shs_isqrt.sv -----
// Pipelined integer square root of f << 30, one root bit per stage.
module shs_isqrt import shs_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [30:0]       frac,
  input  logic [SIDE_W-1:0] side_in,
  output logic [ROOT_W-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STAGES = 31;

  logic [61:0]       v_a    [STAGES+1];
  logic [61:0]       r_a    [STAGES+1];
  logic [SIDE_W-1:0] side_a [STAGES+1];

  assign v_a[0]    = 62'({frac, 30'd0});
  assign r_a[0]    = '0;
  assign side_a[0] = side_in;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int K = STAGES - 1 - j;
    localparam logic [61:0] BITV = 62'd1 << (2 * K);
    logic [61:0] sum;
    logic        ge;

    always_comb begin
      sum = r_a[j] + BITV;
      ge  = (v_a[j] >= sum);
    end

    always_ff @(posedge clk) begin
      v_a[j+1] <= ge ? v_a[j] - sum : v_a[j];
      r_a[j+1] <= ge ? (r_a[j] >> 1) + BITV : r_a[j] >> 1;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_a[j+1] <= '0;
      end else begin
        side_a[j+1] <= side_a[j];
      end
    end
  end

  assign root     = r_a[STAGES][ROOT_W-1:0];
  assign side_out = side_a[STAGES];

endmodule

// ----- hdl/shs_trig.sv -----
// Pipelined Horner evaluation of cos and sin in Q30.
module shs_trig import shs_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [PHI_W-1:0]  phi,
  input  logic [SIDE_W-1:0] side_in,
  output logic [TRIG_W-1:0] cos_q,
  output logic [TRIG_W-1:0] sin_q,
  output logic [SIDE_W-1:0] side_out
);

  localparam logic [TRIG_W-1:0] ONE = TRIG_W'(1) << 30;

  logic [29:0]       x2_a   [6];
  logic [PHI_W-1:0]  phi_a  [6];
  logic [TRIG_W-1:0] tc_a   [6];
  logic [TRIG_W-1:0] ts_a   [6];
  logic [SIDE_W-1:0] side_a [6];
  logic [SIDE_W-1:0] side_f;
  logic [TRIG_W-1:0] cos_f;
  logic [TRIG_W-1:0] sin_f;

  always_ff @(posedge clk) begin
    x2_a[0]  <= 30'((64'(phi) * 64'(phi) + (64'd1 << 29)) >> 30);
    phi_a[0] <= phi;
    tc_a[0]  <= ONE;
    ts_a[0]  <= ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a[0] <= '0;
    end else begin
      side_a[0] <= side_in;
    end
  end

  for (genvar i = 0; i < 5; i++) begin : g_step
    logic [29:0]       x2_p, x2_r;
    logic [PHI_W-1:0]  phi_p, phi_r;
    logic [TRIG_W-1:0] vc_p, vs_p, vc_r, vs_r;
    logic [TRIG_W-1:0] qc_r, qs_r;
    logic [SIDE_W-1:0] side_p, side_r;
    logic [31:0]       remc, rems;
    logic [TRIG_W-1:0] qc, qs;

    always_ff @(posedge clk) begin
      vc_p  <= TRIG_W'((61'(x2_a[i]) * 61'(tc_a[i])) >> 30);
      vs_p  <= TRIG_W'((61'(x2_a[i]) * 61'(ts_a[i])) >> 30);
      x2_p  <= x2_a[i];
      phi_p <= phi_a[i];
      qc_r  <= TRIG_W'((64'(vc_p) * 64'(R_COS[i])) >> 32);
      qs_r  <= TRIG_W'((64'(vs_p) * 64'(R_SIN[i])) >> 32);
      vc_r  <= vc_p;
      vs_r  <= vs_p;
      x2_r  <= x2_p;
      phi_r <= phi_p;
    end

    always_comb begin
      remc = 32'(vc_r) - 32'(qc_r) * 32'(K_COS[i]);
      rems = 32'(vs_r) - 32'(qs_r) * 32'(K_SIN[i]);
      qc   = qc_r + TRIG_W'(remc >= 32'(K_COS[i]));
      qs   = qs_r + TRIG_W'(rems >= 32'(K_SIN[i]));
    end

    always_ff @(posedge clk) begin
      tc_a[i+1]  <= ONE - qc;
      ts_a[i+1]  <= ONE - qs;
      x2_a[i+1]  <= x2_r;
      phi_a[i+1] <= phi_r;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_p      <= '0;
        side_r      <= '0;
        side_a[i+1] <= '0;
      end else begin
        side_p      <= side_a[i];
        side_r      <= side_p;
        side_a[i+1] <= side_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sin_f <= TRIG_W'((61'(phi_a[5]) * 61'(ts_a[5])) >> 30);
    cos_f <= tc_a[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_f <= '0;
    end else begin
      side_f <= side_a[5];
    end
  end

  assign cos_q    = cos_f;
  assign sin_q    = sin_f;
  assign side_out = side_f;

endmodule

// ----- hdl/stratified_hemisphere_sample.sv -----
// Each start beat yields a result that strobes on done.
// Throughput: one beat per cycle; busy stays low, start is never refused.
// Depth is set by the 31-stage dividers, the 31-stage square root and 17 trig stages.
// Reset clears all valid bits and loads grid_dim with 11; results in flight are dropped.
// The receiver cannot stall: every result is shown for exactly one cycle.
module stratified_hemisphere_sample import shs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cell_t      grid_cell,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  output logic       done,
  output dir_t       result
);

  logic [4:0] grid_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dim <= 5'd11;
    end else if (cfg_we) begin
      grid_dim <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // clamp and fold
  logic [4:0] g_c, gm1, cx_c, cy_c;
  logic [5:0] na, nb;

  always_comb begin
    if (grid_dim == 5'd0) begin
      g_c = 5'd1;
    end else if (grid_dim > 5'(GRID_MAX)) begin
      g_c = 5'(GRID_MAX);
    end else begin
      g_c = grid_dim;
    end
    gm1  = g_c - 5'd1;
    cx_c = ({1'b0, grid_cell.cell_x} > gm1) ? gm1 : {1'b0, grid_cell.cell_x};
    cy_c = ({1'b0, grid_cell.cell_y} > gm1) ? gm1 : {1'b0, grid_cell.cell_y};
    na   = {cx_c, 1'b0} - {1'b0, g_c};
    nb   = {cy_c, 1'b0} - {1'b0, g_c};
  end

  logic       s1_valid, s1_na_neg, s1_nb_neg;
  logic [4:0] s1_g, s1_ma, s1_mb;

  always_ff @(posedge clk) begin
    s1_g      <= g_c;
    s1_na_neg <= na[5];
    s1_nb_neg <= nb[5];
    s1_ma     <= na[5] ? 5'(-na) : na[4:0];
    s1_mb     <= nb[5] ? 5'(-nb) : nb[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
  end

  ctx_t       s2_ctx;
  logic [4:0] s2_bm, s2_sm;
  logic [8:0] s2_g2, s2_m2;
  logic       swap;
  logic [4:0] bm, sm;

  always_comb begin
    swap = (s1_ma > s1_mb);
    bm   = swap ? s1_ma : s1_mb;
    sm   = swap ? s1_mb : s1_ma;
  end

  always_ff @(posedge clk) begin
    s2_ctx.na_neg  <= s1_na_neg;
    s2_ctx.nb_neg  <= s1_nb_neg;
    s2_ctx.swap    <= swap;
    s2_ctx.is_null <= (s1_ma == 5'd0) && (s1_mb == 5'd0);
    s2_bm          <= bm;
    s2_sm          <= sm;
    s2_g2          <= 9'(s1_g) * 9'(s1_g);
    s2_m2          <= 9'(bm) * 9'(bm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctx.valid <= 1'b0;
    end else begin
      s2_ctx.valid <= s1_valid;
    end
  end

  ctx_t        s3_ctx;
  logic [4:0]  s3_bm;
  logic [8:0]  s3_g2;
  logic [16:0] s3_den, s3_num;
  logic [34:0] s3_phi_dvd;
  logic [22:0] s3_z_dvd;

  always_ff @(posedge clk) begin
    s3_ctx.na_neg  <= s2_ctx.na_neg;
    s3_ctx.nb_neg  <= s2_ctx.nb_neg;
    s3_ctx.swap    <= s2_ctx.swap;
    s3_ctx.is_null <= s2_ctx.is_null;
    s3_bm          <= s2_bm;
    s3_g2          <= s2_g2;
    s3_den         <= 17'(s2_g2) * 17'(s2_g2);
    s3_num         <= 17'(s2_m2) * 17'({s2_g2, 1'b0} - {1'b0, s2_m2});
    s3_phi_dvd     <= 35'(PI4_Q30) * 35'(s2_sm) + 35'(s2_bm >> 1);
    s3_z_dvd       <= 23'((23'(s2_g2 - s2_m2) << OUT_FRAC_BITS) + 23'(s2_g2 >> 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctx.valid <= 1'b0;
    end else begin
      s3_ctx.valid <= s2_ctx.valid;
    end
  end

  // divide
  logic [30:0] phi_q, f_q, z_q;
  ctx_t        d_ctx;
  logic        f_valid, z_valid;

  shs_div #(.NUM_W(35), .DEN_W(5), .QUO_W(31), .SIDE_W($bits(ctx_t))) u_div_phi (
    .clk(clk), .rst(rst), .dividend(s3_phi_dvd), .divisor(s3_bm),
    .side_in(s3_ctx), .quotient(phi_q), .side_out(d_ctx)
  );

  shs_div #(.NUM_W(47), .DEN_W(17), .QUO_W(31), .SIDE_W(1)) u_div_f (
    .clk(clk), .rst(rst), .dividend({s3_num, 30'd0}), .divisor(s3_den),
    .side_in(s3_ctx.valid), .quotient(f_q), .side_out(f_valid)
  );

  shs_div #(.NUM_W(32), .DEN_W(9), .QUO_W(31), .SIDE_W(1)) u_div_z (
    .clk(clk), .rst(rst), .dividend(32'(s3_z_dvd)), .divisor(s3_g2),
    .side_in(s3_ctx.valid), .quotient(z_q), .side_out(z_valid)
  );

  root_side_t r_in, r_out;

  always_comb begin
    r_in           = '0;
    r_in.ctx       = d_ctx;
    r_in.ctx.valid = d_ctx.valid & f_valid & z_valid;
    r_in.phi       = phi_q[PHI_W-1:0];
    r_in.zq        = z_q[ZQ_W-1:0];
  end

  logic [ROOT_W-1:0] w;

  shs_isqrt #(.SIDE_W($bits(root_side_t))) u_isqrt (
    .clk(clk), .rst(rst), .frac(f_q), .side_in(r_in), .root(w), .side_out(r_out)
  );

  trig_side_t        t_in, t_out;
  logic [TRIG_W-1:0] cos_q, sin_q;

  always_comb begin
    t_in.ctx = r_out.ctx;
    t_in.zq  = r_out.zq;
    t_in.w   = w;
  end

  shs_trig #(.SIDE_W($bits(trig_side_t))) u_trig (
    .clk(clk), .rst(rst), .phi(r_out.phi), .side_in(t_in),
    .cos_q(cos_q), .sin_q(sin_q), .side_out(t_out)
  );

  // scale and sign
  ctx_t            o1_ctx;
  logic [61:0]     o1_px, o1_py;
  logic [ZQ_W-1:0] o1_zq;

  always_ff @(posedge clk) begin
    o1_ctx.na_neg  <= t_out.ctx.na_neg;
    o1_ctx.nb_neg  <= t_out.ctx.nb_neg;
    o1_ctx.swap    <= t_out.ctx.swap;
    o1_ctx.is_null <= t_out.ctx.is_null;
    o1_px          <= 62'(t_out.w) * 62'(t_out.ctx.swap ? cos_q : sin_q);
    o1_py          <= 62'(t_out.w) * 62'(t_out.ctx.swap ? sin_q : cos_q);
    o1_zq          <= t_out.zq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_ctx.valid <= 1'b0;
    end else begin
      o1_ctx.valid <= t_out.ctx.valid;
    end
  end

  localparam logic [61:0] HALF = 62'd1 << (OUT_SHIFT - 1);
  localparam logic [15:0] LIM  = 16'(OUT_LIM);

  logic [15:0] mx, my, mz, sx, sy, sz;

  always_comb begin
    mx = 16'((o1_px + HALF) >> OUT_SHIFT);
    my = 16'((o1_py + HALF) >> OUT_SHIFT);
    mz = 16'(o1_zq);
    sx = (mx > LIM) ? LIM : mx;
    sy = (my > LIM) ? LIM : my;
    sz = (mz > LIM) ? LIM : mz;
  end

  always_ff @(posedge clk) begin
    if (o1_ctx.is_null) begin
      result <= '{dir_x: '0, dir_y: '0, dir_z: '0, is_null: 1'b1};
    end else begin
      result.dir_x   <= o1_ctx.na_neg ? -sx : sx;
      result.dir_y   <= o1_ctx.nb_neg ? -sy : sy;
      result.dir_z   <= sz;
      result.is_null <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= o1_ctx.valid;
    end
  end

endmodule

// ----- hdl/shs_check.sv -----
// Port-level checker for the stratified hemisphere sampler, with its bind.
`include "stratified_hemisphere_sample_macros.svh"

module shs_check import shs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done,
  input dir_t result
);

  `SHS_ASSERT_NEXT(a_reset_quiet, rst, !done && !busy, "result beat right after reset")
  `SHS_ASSERT_IMPLY(a_null_zero, done && result.is_null, (result.dir_x == 16'sd0) && (result.dir_y == 16'sd0) && (result.dir_z == 16'sd0), "null beat with nonzero direction")
  `SHS_ASSERT_IMPLY(a_z_range, done, !result.dir_z[15] && (result.dir_z <= 16'sd16384), "dir_z out of range")
  `SHS_ASSERT_IMPLY(a_xy_range, done, (result.dir_x >= -16'sd16384) && (result.dir_x <= 16'sd16384) && (result.dir_y >= -16'sd16384) && (result.dir_y <= 16'sd16384), "dir_x or dir_y out of range")

endmodule

bind stratified_hemisphere_sample shs_check u_shs_check (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .done(done),
  .result(result)
);
